>>> hw/rtl/bicc_pkg.sv
package bicc_pkg;

    localparam int COUNT_W = 12;
    localparam int DIM_W   = 7;

    typedef struct packed {
        logic             eight;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_POP,
        ST_NBR,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/bicc_ram.sv
module bicc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bicc_cfg.sv
module bicc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bicc_pkg::t_cfg o_cfg
);

    import bicc_pkg::*;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

    logic             r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (w_write) begin
            case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, r_mode};
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.eight  = r_mode;
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

endmodule

>>> hw/rtl/bicc_engine.sv
module bicc_engine #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bicc_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_pixel,
    input  logic                          i_last,
    output logic                          o_res_valid,
    output logic [bicc_pkg::COUNT_W-1:0]  o_res_count,
    input  logic                          i_res_ready
);

    import bicc_pkg::*;

    localparam int CAP    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(CAP);
    localparam int LCNT_W = $clog2(CAP + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int SE_W   = ADDR_W + ROW_W + COL_W;

    localparam logic [LCNT_W-1:0]  LOAD_FULL = LCNT_W'(CAP);
    localparam logic [2:0]         K_LAST4   = 3'd3;
    localparam logic [2:0]         K_LAST8   = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    t_state             r_state;
    t_state             n_state;
    logic [LCNT_W-1:0]  r_load,   n_load;
    logic [LCNT_W-1:0]  r_sp,     n_sp;
    logic               r_eight,  n_eight;
    logic [WD_W-1:0]    r_w,      n_w;
    logic [HD_W-1:0]    r_h,      n_h;
    logic [ADDR_W-1:0]  r_scan_p, n_scan_p;
    logic [HD_W-1:0]    r_scan_r, n_scan_r;
    logic [COL_W-1:0]   r_scan_c, n_scan_c;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [2:0]         r_k,      n_k;
    logic               r_cv,     n_cv;
    logic [ADDR_W-1:0]  r_cand_p, n_cand_p;
    logic [ROW_W-1:0]   r_cand_r, n_cand_r;
    logic [COL_W-1:0]   r_cand_c, n_cand_c;

    logic              pix_we, pix_re;
    logic [ADDR_W-1:0] pix_wa, pix_ra;
    logic [1:0]        pix_wd, pix_rd;
    logic              stk_we, stk_re;
    logic [ADDR_W-1:0] stk_wa, stk_ra;
    logic [SE_W-1:0]   stk_wd, stk_rd;

    logic              w_accept;
    logic              w_push;
    logic              w_scan_issue;
    logic              w_scan_wrap;
    logic [2:0]        w_k_last;
    logic [ADDR_W-1:0] w_cur_p;
    logic [ROW_W-1:0]  w_cur_r;
    logic [COL_W-1:0]  w_cur_c;
    logic              w_dc_pos, w_dc_neg, w_dr_pos, w_dr_neg;
    logic              w_inb;
    logic [ADDR_W-1:0] w_base, w_nbr_p;
    logic [ROW_W-1:0]  w_nbr_r;
    logic [COL_W-1:0]  w_nbr_c;
    logic [WD_W-1:0]   w_clamp_w;
    logic [HD_W-1:0]   w_clamp_h;
    logic [LCNT_W-1:0] w_sp_dec;

    bicc_ram #(.WIDTH(2), .DEPTH(CAP)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_wa),
        .i_wdata (pix_wd),
        .i_re    (pix_re),
        .i_raddr (pix_ra),
        .o_rdata (pix_rd)
    );

    bicc_ram #(.WIDTH(SE_W), .DEPTH(CAP)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_wa),
        .i_wdata (stk_wd),
        .i_re    (stk_re),
        .i_raddr (stk_ra),
        .o_rdata (stk_rd)
    );

    // Pixel memory entries hold {visited, foreground}; loading an entry clears its mark.
    assign w_accept = i_in_valid & o_in_ready;
    assign w_push   = r_cv && (r_state == ST_SCAN || r_state == ST_NBR || r_state == ST_DRAIN)
                      && (LCNT_W'(r_cand_p) < r_load) && pix_rd[0] && !pix_rd[1];

    assign w_scan_issue = (r_scan_r != r_h);
    assign w_scan_wrap  = ((WD_W'(r_scan_c) + WD_W'(1)) == r_w);
    assign w_k_last     = r_eight ? K_LAST8 : K_LAST4;
    assign w_sp_dec     = r_sp - LCNT_W'(1);

    assign w_clamp_w = (i_cfg.width == '0) ? WD_W'(1) :
                       (32'(i_cfg.width) > 32'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) :
                       WD_W'(i_cfg.width);
    assign w_clamp_h = (i_cfg.height == '0) ? HD_W'(1) :
                       (32'(i_cfg.height) > 32'(MAX_HEIGHT)) ? HD_W'(MAX_HEIGHT) :
                       HD_W'(i_cfg.height);

    assign w_cur_p = stk_rd[SE_W-1 -: ADDR_W];
    assign w_cur_r = stk_rd[COL_W +: ROW_W];
    assign w_cur_c = stk_rd[COL_W-1:0];

    assign w_dc_pos = (r_k == 3'd0) || (r_k == 3'd4) || (r_k == 3'd5);
    assign w_dc_neg = (r_k == 3'd1) || (r_k == 3'd6) || (r_k == 3'd7);
    assign w_dr_pos = (r_k == 3'd2) || (r_k == 3'd4) || (r_k == 3'd6);
    assign w_dr_neg = (r_k == 3'd3) || (r_k == 3'd5) || (r_k == 3'd7);

    assign w_inb = !(w_dc_pos && ((WD_W'(w_cur_c) + WD_W'(1)) == r_w))
                && !(w_dc_neg && (w_cur_c == '0))
                && !(w_dr_pos && ((HD_W'(w_cur_r) + HD_W'(1)) == r_h))
                && !(w_dr_neg && (w_cur_r == '0));

    assign w_base  = w_dr_pos ? (w_cur_p + ADDR_W'(r_w)) :
                     w_dr_neg ? (w_cur_p - ADDR_W'(r_w)) : w_cur_p;
    assign w_nbr_p = w_dc_pos ? (w_base + ADDR_W'(1)) :
                     w_dc_neg ? (w_base - ADDR_W'(1)) : w_base;
    assign w_nbr_r = w_dr_pos ? (w_cur_r + ROW_W'(1)) :
                     w_dr_neg ? (w_cur_r - ROW_W'(1)) : w_cur_r;
    assign w_nbr_c = w_dc_pos ? (w_cur_c + COL_W'(1)) :
                     w_dc_neg ? (w_cur_c - COL_W'(1)) : w_cur_c;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_push) begin
                    n_state = ST_POP;
                end else if (!w_scan_issue && !r_cv) begin
                    n_state = ST_DONE;
                end
            end
            ST_POP: begin
                n_state = ST_NBR;
            end
            ST_NBR: begin
                if (r_k == w_k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_push || (r_sp != '0)) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_load   = r_load;
        n_sp     = r_sp;
        n_eight  = r_eight;
        n_w      = r_w;
        n_h      = r_h;
        n_scan_p = r_scan_p;
        n_scan_r = r_scan_r;
        n_scan_c = r_scan_c;
        n_count  = r_count;
        n_k      = r_k;
        n_cv     = r_cv;
        n_cand_p = r_cand_p;
        n_cand_r = r_cand_r;
        n_cand_c = r_cand_c;
        pix_we   = 1'b0;
        pix_wa   = r_cand_p;
        pix_wd   = 2'b11;
        pix_re   = 1'b0;
        pix_ra   = r_scan_p;
        stk_we   = 1'b0;
        stk_wa   = r_sp[ADDR_W-1:0];
        stk_wd   = {r_cand_p, r_cand_r, r_cand_c};
        stk_re   = 1'b0;
        stk_ra   = w_sp_dec[ADDR_W-1:0];
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        if (w_push) begin
            pix_we = 1'b1;
            stk_we = 1'b1;
            n_sp   = r_sp + LCNT_W'(1);
        end

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    if (r_load != LOAD_FULL) begin
                        pix_we = 1'b1;
                        pix_wa = r_load[ADDR_W-1:0];
                        pix_wd = {1'b0, i_pixel};
                        n_load = r_load + LCNT_W'(1);
                    end
                    if (i_last) begin
                        n_eight  = i_cfg.eight;
                        n_w      = w_clamp_w;
                        n_h      = w_clamp_h;
                        n_scan_p = '0;
                        n_scan_r = '0;
                        n_scan_c = '0;
                        n_count  = '0;
                        n_cv     = 1'b0;
                        n_sp     = '0;
                    end
                end
            end
            ST_SCAN: begin
                pix_re   = w_scan_issue;
                pix_ra   = r_scan_p;
                n_cv     = w_scan_issue && !w_push;
                n_cand_p = r_scan_p;
                n_cand_r = ROW_W'(r_scan_r);
                n_cand_c = r_scan_c;
                n_k      = '0;
                if (w_push) begin
                    if (r_count != COUNT_SAT) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else if (w_scan_issue) begin
                    n_scan_p = r_scan_p + ADDR_W'(1);
                    if (w_scan_wrap) begin
                        n_scan_c = '0;
                        n_scan_r = r_scan_r + HD_W'(1);
                    end else begin
                        n_scan_c = r_scan_c + COL_W'(1);
                    end
                end
            end
            ST_POP: begin
                stk_re = 1'b1;
                n_sp   = w_sp_dec;
                n_k    = '0;
                n_cv   = 1'b0;
            end
            ST_NBR: begin
                pix_re   = w_inb;
                pix_ra   = w_nbr_p;
                n_cv     = w_inb;
                n_cand_p = w_nbr_p;
                n_cand_r = w_nbr_r;
                n_cand_c = w_nbr_c;
                n_k      = r_k + 3'd1;
            end
            ST_DRAIN: begin
                n_cv = 1'b0;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_load = '0;
                end
            end
            default: ;
        endcase
    end

    assign o_res_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_load  <= '0;
            r_sp    <= '0;
            r_eight <= 1'b0;
            r_w     <= WD_W'(1);
            r_h     <= HD_W'(1);
            r_scan_p <= '0;
            r_scan_r <= '0;
            r_scan_c <= '0;
            r_count <= '0;
            r_k     <= '0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_sp    <= n_sp;
            r_eight <= n_eight;
            r_w     <= n_w;
            r_h     <= n_h;
            r_scan_p <= n_scan_p;
            r_scan_r <= n_scan_r;
            r_scan_c <= n_scan_c;
            r_count <= n_count;
            r_k     <= n_k;
            r_cv    <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_p <= n_cand_p;
        r_cand_r <= n_cand_r;
        r_cand_c <= n_cand_c;
    end

endmodule

>>> hw/rtl/binary_image_component_counter_core.sv
// Channel   Direction  Contents
// s_axis    in         tdata[0] pixel_bit, tlast last_pixel
// m_axis    out        tdata[11:0] component_count
// apb       in         connectivity_mode @0x0, image_width @0x4, image_height @0x8
//
// Pixels load at one per cycle. After the last pixel, the raster scan reads each pixel in
// turn, and each foreground pixel costs a stack pop, a read of each neighbor (4 or 8) and
// a drain step, one read at a time through the single read port of the pixel memory.
// Reset is synchronous and needs no clearing pass; entries past the load count read as
// background. Input is taken only while loading; a finished count waits in the output
// register, and the next image loads while it is held.
module binary_image_component_counter_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pixel_bit, [7:1] zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] component_count, [15:12] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bicc_pkg::*;

    t_cfg               cfg;
    logic               res_valid;
    logic               res_ready;
    logic [COUNT_W-1:0] res_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    bicc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bicc_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_pixel     (s_axis_tdata[0]),
        .i_last      (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res_count (res_count),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_count <= res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16-COUNT_W){1'b0}}, r_out_count};

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bicc_pkg::*;

    localparam int CAPACITY    = 64 * 64;
    localparam int COUNT_MAX   = 4095;
    localparam int QUIET_LIMIT = 200000;
    localparam int LOAD_SETTLE = 16;
    localparam int LONG_HOLD   = 8000;
    localparam int DRAIN_WAIT  = 100;
    localparam int RANDOM_ITEMS = 850;

    localparam logic [3:0] ADDR_MODE   = 4'h0;
    localparam logic [3:0] ADDR_WIDTH  = 4'h4;
    localparam logic [3:0] ADDR_HEIGHT = 4'h8;

    typedef enum int {
        PAT_EMPTY,
        PAT_FULL,
        PAT_SPARSE,
        PAT_HALF,
        PAT_DENSE,
        PAT_CHECKER,
        PAT_DIAG
    } t_pattern;

    class t_count_tracker;
        bit                 eight;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        bit                 pixels [CAPACITY];
        bit                 seen [CAPACITY];
        int                 fill [CAPACITY];
        int                 sp;
        int                 load_pos;
        logic [COUNT_W-1:0] counts_due [$];
        int                 errors;

        function new();
            eight      = 1'b0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            sp         = 0;
            load_pos   = 0;
            errors     = 0;
            foreach (pixels[i]) begin
                pixels[i] = 1'b0;
                seen[i]   = 1'b0;
            end
        endfunction

        function int clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > 64) return 64;
            return int'(v);
        endfunction

        function void set_register(logic [3:0] addr, logic [31:0] value);
            case (addr)
                ADDR_MODE:   eight      = value[0];
                ADDR_WIDTH:  width_reg  = value[DIM_W-1:0];
                ADDR_HEIGHT: height_reg = value[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void try_mark(int r, int c, int w, int h);
            int p;
            if (r < 0 || c < 0 || r >= h || c >= w) return;
            p = r * w + c;
            if (p >= CAPACITY || !pixels[p] || seen[p]) return;
            seen[p] = 1'b1;
            if (sp < CAPACITY) begin
                fill[sp] = p;
                sp++;
            end
        endfunction

        function logic [COUNT_W-1:0] count_components();
            int w;
            int h;
            int total;
            int p;
            int r;
            int c;
            int found;
            w     = clamp_dim(width_reg);
            h     = clamp_dim(height_reg);
            total = w * h;
            found = 0;
            for (int s = 0; s < total && s < CAPACITY; s++) begin
                if (pixels[s] && !seen[s]) begin
                    seen[s] = 1'b1;
                    fill[0] = s;
                    sp      = 1;
                    while (sp > 0) begin
                        sp--;
                        p = fill[sp];
                        r = p / w;
                        c = p % w;
                        try_mark(r, c + 1, w, h);
                        try_mark(r, c - 1, w, h);
                        try_mark(r + 1, c, w, h);
                        try_mark(r - 1, c, w, h);
                        if (eight) begin
                            try_mark(r + 1, c + 1, w, h);
                            try_mark(r - 1, c + 1, w, h);
                            try_mark(r + 1, c - 1, w, h);
                            try_mark(r - 1, c - 1, w, h);
                        end
                    end
                    if (found < COUNT_MAX) found++;
                end
            end
            return found[COUNT_W-1:0];
        endfunction

        function void note_pixel(bit pix, bit last);
            if (load_pos < CAPACITY) begin
                pixels[load_pos] = pix;
                load_pos++;
            end
            if (last) begin
                counts_due.push_back(count_components());
                foreach (pixels[i]) begin
                    pixels[i] = 1'b0;
                    seen[i]   = 1'b0;
                end
                load_pos = 0;
            end
        endfunction

        function void check_count(logic [15:0] data);
            logic [COUNT_W-1:0] want;
            if (counts_due.size() == 0) begin
                $error("component_count: no result expected, actual %0d", data[COUNT_W-1:0]);
                errors++;
                return;
            end
            want = counts_due.pop_front();
            if (data[COUNT_W-1:0] !== want) begin
                $error("component_count: expected %0d, actual %0d", want, data[COUNT_W-1:0]);
                errors++;
            end
            if (data[15:COUNT_W] !== '0) begin
                $error("tdata padding: expected 0, actual %0h", data[15:COUNT_W]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_count_tracker sb = new();
    int             burst_left   = 0;
    int             quiet_cycles = 0;
    bit             hold_request = 1'b0;

    binary_image_component_counter_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit pattern_pixel(t_pattern style, int idx);
        int w;
        int r;
        int c;
        w = sb.clamp_dim(sb.width_reg);
        r = idx / w;
        c = idx % w;
        case (style)
            PAT_EMPTY:   return 1'b0;
            PAT_FULL:    return 1'b1;
            PAT_SPARSE:  return $urandom_range(0, 7) == 0;
            PAT_HALF:    return $urandom_range(0, 1) == 1;
            PAT_DENSE:   return $urandom_range(0, 3) != 0;
            PAT_CHECKER: return ((r + c) % 2) == 0;
            default:     return ((r + 2 * c) % 3) == 0;
        endcase
    endfunction

    function automatic int image_pixels();
        return sb.clamp_dim(sb.width_reg) * sb.clamp_dim(sb.height_reg);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        if ($urandom_range(0, 7) == 0) return DIM_W'($urandom_range(0, 127));
        return DIM_W'($urandom_range(1, 8));
    endfunction

    task automatic send_pixel(bit pix, bit last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pix};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        sb.note_pixel(pix, last);
    endtask

    task automatic send_run(t_pattern style, int first, int count, bit close);
        for (int i = 0; i < count; i++) begin
            send_pixel(pattern_pixel(style, first + i), close && (i == count - 1));
        end
    endtask

    task automatic send_bits(bit pixel_seq [$], bit close);
        foreach (pixel_seq[i]) begin
            send_pixel(pixel_seq[i], close && (i == pixel_seq.size() - 1));
        end
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.counts_due.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [3:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(addr, value);
        @(posedge i_clk);
    endtask

    task automatic configure(bit eight, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        settle_idle();
        apb_write(ADDR_MODE, {31'd0, eight});
        apb_write(ADDR_WIDTH, {25'd0, w});
        apb_write(ADDR_HEIGHT, {25'd0, h});
    endtask

    task automatic configure_random();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        w = random_dim();
        h = random_dim();
        if (sb.clamp_dim(w) * sb.clamp_dim(h) > 512) h = DIM_W'($urandom_range(1, 4));
        configure($urandom_range(0, 1) == 1, w, h);
    endtask

    initial begin : receiver
        int stretch;
        int kind;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            kind    = $urandom_range(0, 3);
            stretch = $urandom_range(1, 40);
            repeat (stretch) begin
                case (kind)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'b0;
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_count(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int       random_items;
        int       total;
        int       first;
        int       rest;
        t_pattern style;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single pixel images, foreground and background.
        configure(1'b0, 7'd1, 7'd1);
        send_bits('{1'b1}, 1'b1);
        send_bits('{1'b0}, 1'b1);

        // Diagonal pair separates four- from eight-neighbour connectivity.
        configure(1'b0, 7'd2, 7'd2);
        send_bits('{1'b1, 1'b0, 1'b0, 1'b1}, 1'b1);
        configure(1'b1, 7'd2, 7'd2);
        send_bits('{1'b1, 1'b0, 1'b0, 1'b1}, 1'b1);

        // A zero width behaves as a single column.
        configure(1'b1, 7'd0, 7'd3);
        send_bits('{1'b1, 1'b0, 1'b1}, 1'b1);

        // Pixels past the image area are loaded but not counted.
        configure(1'b0, 7'd2, 7'd1);
        send_bits('{1'b1, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1);

        // Dimensions change while the image is partly loaded.
        configure(1'b0, 7'd3, 7'd1);
        send_bits('{1'b1, 1'b0}, 1'b0);
        configure(1'b0, 7'd1, 7'd3);
        send_bits('{1'b1}, 1'b1);

        // The receiver holds off while three images are offered, so the input stalls.
        configure(1'b1, 7'd127, 7'd2);
        hold_request = 1'b1;
        send_run(PAT_FULL, 0, image_pixels(), 1'b1);
        send_run(PAT_EMPTY, 0, image_pixels(), 1'b1);
        send_run(PAT_EMPTY, 0, image_pixels(), 1'b1);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) configure_random();
            style = t_pattern'($urandom_range(0, PAT_DIAG));
            total = image_pixels();
            if ($urandom_range(0, 4) == 0) total += $urandom_range(1, 6);
            if ($urandom_range(0, 11) == 0) begin
                first = $urandom_range(1, total);
                send_run(style, 0, first, 1'b0);
                configure_random();
                total = image_pixels();
                rest  = (total > first) ? total - first : 1;
                send_run(style, first, rest, 1'b1);
                random_items += first + rest;
            end else begin
                send_run(style, 0, total, 1'b1);
                random_items += total;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.counts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
